>>> sv/dle_character_stuffing_framer_macros.svh
// assertion helpers shared by the framer modules
`ifndef DLE_CHARACTER_STUFFING_FRAMER_MACROS_SVH
`define DLE_CHARACTER_STUFFING_FRAMER_MACROS_SVH

// checked only outside reset
`define DLECS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define DLECS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/dlecs_pkg.sv
package dlecs_pkg;

  localparam int MAX_LEN_DEF = 255;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_L = 8'h6C;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_S = 8'h73;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_X = 8'h78;

  // register indexes
  localparam logic REG_INSERT_POSITION = 1'b0;
  localparam logic REG_INSERT_CHAR     = 1'b1;

  // last sub-step of the header, insert, stuff and trailer segments; INS_MID is the insert_char sub-step
  localparam logic [2:0] HDR_LAST   = 3'd5;
  localparam logic [2:0] INS_LAST   = 3'd6;
  localparam logic [2:0] INS_MID    = 3'd3;
  localparam logic [2:0] STUFF_LAST = 3'd2;
  localparam logic [2:0] TRL_LAST   = 3'd5;

  typedef enum logic [2:0] {
    PH_START,
    PH_HDR,
    PH_INS,
    PH_STUFF,
    PH_CHAR,
    PH_TRL
  } ph_t;

  // one input item, classified
  typedef struct packed {
    logic             hdr;
    logic             trl;
    logic [1:0]       cnt;
    logic [2:0][7:0]  chars;
    logic [2:0]       ins;
    logic             stuff;
    logic [7:0]       ins_char;
  } cmd_t;

  function automatic logic [7:0] dle_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = CH_D;
      2'd1:    b = CH_L;
      default: b = CH_E;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = CH_D;
      3'd1:    b = CH_L;
      3'd2:    b = CH_E;
      3'd3:    b = CH_S;
      3'd4:    b = CH_T;
      default: b = CH_X;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] trl_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = CH_D;
      3'd1:    b = CH_L;
      3'd2:    b = CH_E;
      3'd3:    b = CH_E;
      3'd4:    b = CH_T;
      default: b = CH_X;
    endcase
    return b;
  endfunction

endpackage

>>> sv/dlecs_if.sv
interface dlecs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_char;

  modport source (output valid, output data_byte, output last_char, input ready);
  modport sink (input valid, input data_byte, input last_char, output ready);
endinterface

interface dlecs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input frame_end,
                output ready);
endinterface

>>> sv/dle_character_stuffing_framer.sv
// dle/stx character stuffing framer
// in_ch takes one character per beat, last_char marks the end of the string.
// out_ch gives the framed stream one byte per beat: header "dlestx" when a
// frame opens, the data with "dle" stuffed before every "dle" in the data,
// "dle", insert_char, "dle" before the character at insert_position (one-based,
// zero for none), and the trailer "dleetx" after the last character.
// run_last marks the final output beat caused by an input beat, frame_end the
// final trailer byte. two characters are held back as lookahead, so the
// second character of a string gives no output.
// an accepted beat is written into the command queue at the accepting edge,
// and the sequencer then loads its first output byte into the output register.
// throughput: the output sequencer emits one byte per cycle while the receiver
// takes it; a beat that enters the queue makes from one to 20 output bytes, a
// beat that makes no output does not enter it. the command queue lets the input
// side run ahead by the queue depth.
// reset clears the lookahead, the queue and the output register; no frame is
// open afterwards. when the receiver stalls the output register holds its
// beat and input is taken until the queue fills.
// registers: 0 insert_position, 4 insert_char, written by apb.
module dle_character_stuffing_framer #(
  parameter int MAX_LEN = dlecs_pkg::MAX_LEN_DEF,
  parameter int Q_DEPTH = dlecs_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  dlecs_in_if.sink    in_ch,
  dlecs_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dlecs_pkg::*;

  logic [7:0] insert_position;
  logic [7:0] insert_char;
  logic       cfg_wr;

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_pop, q_full, q_nonempty;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      insert_position <= '0;
      insert_char     <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_INSERT_POSITION: insert_position <= pwdata[7:0];
        REG_INSERT_CHAR:     insert_char     <= pwdata[7:0];
        default:             insert_char     <= insert_char;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INSERT_POSITION: prdata = {24'd0, insert_position};
      REG_INSERT_CHAR:     prdata = {24'd0, insert_char};
      default:             prdata = '0;
    endcase
  end

  dlecs_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_ch           (in_ch),
    .insert_position (insert_position),
    .insert_char     (insert_char),
    .q_full          (q_full),
    .cmd_push        (cmd_push),
    .cmd             (cmd_in)
  );

  dlecs_fifo #(
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .wdata    (cmd_in),
    .pop      (cmd_pop),
    .rdata    (cmd_out),
    .nonempty (q_nonempty),
    .full     (q_full)
  );

  dlecs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_valid (q_nonempty),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule

>>> sv/dlecs_front.sv
`include "dle_character_stuffing_framer_macros.svh"

module dlecs_front #(
  parameter int MAX_LEN = dlecs_pkg::MAX_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst,
  dlecs_in_if.sink        in_ch,
  input  logic [7:0]      insert_position,
  input  logic [7:0]      insert_char,
  input  logic            q_full,
  output logic            cmd_push,
  output dlecs_pkg::cmd_t cmd
);
  import dlecs_pkg::*;

  localparam int CIW = $clog2(MAX_LEN + 1);
  localparam int CW  = (CIW + 1 > 9) ? CIW + 1 : 9;

  logic [7:0]     held0, held1;
  logic [1:0]     held_count;
  logic [CIW-1:0] char_index;
  logic           in_frame;

  logic [1:0]     hc;
  logic [CIW-1:0] ci, ci_inc;
  logic [7:0]     c, b0, b1, b2;
  logic           cnt3, accept;
  logic [CW-1:0]  idx [3];
  logic [CW-1:0]  target;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.data_byte;

  always_comb begin
    // a new frame starts from an empty lookahead
    hc = in_frame ? ((held_count > 2'd2) ? 2'd2 : held_count) : 2'd0;
    ci = in_frame ? char_index : '0;
    b0 = (hc >= 2'd1) ? held0 : c;
    b1 = (hc >= 2'd2) ? held1 : c;
    b2 = c;
    cnt3 = (hc == 2'd2);
    ci_inc = (ci < CIW'(MAX_LEN)) ? ci + CIW'(1) : ci;
    target = CW'(insert_position) - CW'(1);
    for (int i = 0; i < 3; i++) begin
      idx[i] = CW'(ci) + CW'(i);
      if (idx[i] > CW'(MAX_LEN)) begin
        idx[i] = CW'(MAX_LEN);
      end
    end
  end

  always_comb begin
    cmd.hdr      = !in_frame;
    cmd.trl      = in_ch.last_char;
    cmd.cnt      = in_ch.last_char ? (hc + 2'd1) : {1'b0, cnt3};
    cmd.chars    = {b2, b1, b0};
    cmd.stuff    = cnt3 && (b0 == CH_D) && (b1 == CH_L) && (b2 == CH_E);
    cmd.ins_char = insert_char;
    for (int i = 0; i < 3; i++) begin
      cmd.ins[i] = (insert_position != 8'd0) && (idx[i] == target);
    end
    cmd_push = accept && (!in_frame || in_ch.last_char || cnt3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held0      <= '0;
      held1      <= '0;
      held_count <= '0;
      char_index <= '0;
      in_frame   <= 1'b0;
    end else if (accept) begin
      if (in_ch.last_char) begin
        held0      <= '0;
        held1      <= '0;
        held_count <= '0;
        char_index <= '0;
        in_frame   <= 1'b0;
      end else if (cnt3) begin
        held0      <= b1;
        held1      <= b2;
        held_count <= 2'd2;
        char_index <= ci_inc;
        in_frame   <= 1'b1;
      end else begin
        held0      <= b0;
        held1      <= (hc == 2'd1) ? b1 : 8'd0;
        held_count <= hc + 2'd1;
        char_index <= ci;
        in_frame   <= 1'b1;
      end
    end
  end

  `DLECS_ASSERT(a_closed_frame_clean, !in_frame |-> (held_count == 2'd0 && char_index == '0), "state left over outside a frame")

endmodule

>>> sv/dlecs_fifo.sv
`include "dle_character_stuffing_framer_macros.svh"

module dlecs_fifo #(
  parameter int DEPTH = dlecs_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dlecs_pkg::cmd_t wdata,
  input  logic            pop,
  output dlecs_pkg::cmd_t rdata,
  output logic            nonempty,
  output logic            full
);
  import dlecs_pkg::*;

  // depth of at least two
  localparam int PW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  cmd_t           mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CNW-1:0] count;
  logic           do_push, do_pop;

  assign full     = (count == CNW'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rdata    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CNW'(do_push) - CNW'(do_pop);
    end
  end

  `DLECS_ASSERT(a_no_push_when_full, push |-> !full, "command pushed into a full queue")

endmodule

>>> sv/dlecs_back.sv
`include "dle_character_stuffing_framer_macros.svh"

module dlecs_back (
  input  logic            clk,
  input  logic            rst,
  input  dlecs_pkg::cmd_t cmd,
  input  logic            cmd_valid,
  output logic            cmd_pop,
  dlecs_out_if.source     out_ch
);
  import dlecs_pkg::*;

  ph_t        ph, ph_next, ep;
  logic [1:0] sl, sl_next, sl_inc;
  logic [2:0] sub, sub_next, ins_off;
  logic       seg_last, done, adv;
  logic [7:0] byte_d;
  logic       fe_d;

  logic       ov;
  logic [7:0] ob;
  logic       orl, ofe;

  function automatic ph_t first_seg(input logic ins, input logic stf);
    ph_t p;
    if (ins) begin
      p = PH_INS;
    end else if (stf) begin
      p = PH_STUFF;
    end else begin
      p = PH_CHAR;
    end
    return p;
  endfunction

  assign adv     = cmd_valid && (!ov || out_ch.ready);
  assign cmd_pop = adv && done;
  assign sl_inc  = sl + 2'd1;

  // next position within the current command
  always_comb begin
    ep = (ph == PH_START) ? (cmd.hdr ? PH_HDR : first_seg(cmd.ins[0], cmd.stuff)) : ph;
    unique case (ep)
      PH_HDR:   seg_last = (sub == HDR_LAST);
      PH_INS:   seg_last = (sub == INS_LAST);
      PH_STUFF: seg_last = (sub == STUFF_LAST);
      PH_CHAR:  seg_last = 1'b1;
      PH_TRL:   seg_last = (sub == TRL_LAST);
      default:  seg_last = 1'b1;
    endcase
    ph_next  = ep;
    sl_next  = sl;
    sub_next = sub + 3'd1;
    done     = 1'b0;
    if (seg_last) begin
      sub_next = '0;
      unique case (ep)
        PH_HDR: begin
          if (cmd.cnt != 2'd0) begin
            ph_next = first_seg(cmd.ins[0], cmd.stuff);
          end else begin
            done = 1'b1;
          end
        end
        PH_INS: begin
          ph_next = (cmd.stuff && sl == 2'd0) ? PH_STUFF : PH_CHAR;
        end
        PH_STUFF: begin
          ph_next = PH_CHAR;
        end
        PH_CHAR: begin
          if (sl_inc < cmd.cnt) begin
            sl_next = sl_inc;
            ph_next = first_seg(cmd.ins[sl_inc], 1'b0);
          end else if (cmd.trl) begin
            ph_next = PH_TRL;
          end else begin
            done = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (done) begin
        ph_next = PH_START;
        sl_next = '0;
      end
    end
  end

  // byte for the current position
  always_comb begin
    ins_off = (sub > INS_MID) ? sub - 3'd4 : sub;
    fe_d    = 1'b0;
    unique case (ep)
      PH_HDR:   byte_d = hdr_byte(sub);
      PH_INS:   byte_d = (sub == INS_MID) ? cmd.ins_char : dle_byte(ins_off[1:0]);
      PH_STUFF: byte_d = dle_byte(sub[1:0]);
      PH_CHAR:  byte_d = cmd.chars[sl];
      PH_TRL: begin
        byte_d = trl_byte(sub);
        fe_d   = (sub == TRL_LAST);
      end
      default:  byte_d = cmd.chars[sl];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph  <= PH_START;
      sl  <= '0;
      sub <= '0;
      ov  <= 1'b0;
    end else begin
      if (adv) begin
        ph  <= ph_next;
        sl  <= sl_next;
        sub <= sub_next;
        ov  <= 1'b1;
      end else if (out_ch.ready) begin
        ov  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ob  <= byte_d;
      orl <= done;
      ofe <= fe_d;
    end
  end

  assign out_ch.valid     = ov;
  assign out_ch.out_byte  = ob;
  assign out_ch.run_last  = orl;
  assign out_ch.frame_end = ofe;

  `DLECS_ASSERT(a_mid_cmd_has_cmd, (ph != PH_START) |-> cmd_valid, "sequencer mid-command with empty queue")
  `DLECS_ASSERT(a_frame_end_is_last, (ov && ofe) |-> orl, "trailer end not marked as last beat")
  `DLECS_ASSERT_ALWAYS(a_reset_empties_out, rst |=> !ov, "output register valid after reset")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dlecs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } frame_beat_t;

  // directed rows: optional register writes, one character, result count
  typedef struct {
    bit         cfg;
    logic [7:0] pos;
    logic [7:0] chr;
    logic [7:0] ch;
    logic       lst;
    int         exp_n;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dlecs_in_if  in_ch ();
  dlecs_out_if out_ch ();

  dle_character_stuffing_framer uut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // framer state as the testbench sees it
  logic [7:0]  ins_pos   = 8'd0;
  logic [7:0]  ins_chr   = 8'd0;
  logic [7:0]  look_q [2] = '{8'd0, 8'd0};
  logic [1:0]  look_cnt  = 2'd0;
  logic [7:0]  char_pos  = 8'd0;
  logic        frame_open = 1'b0;

  frame_beat_t beat_q [$];
  frame_beat_t exp_beat;

  int  fail_cnt      = 0;
  int  cycles        = 0;
  int  chars_sent    = 0;
  int  frames_sent   = 0;
  int  bytes_checked = 0;
  int  regs_written  = 0;
  bit  src_burst     = 1'b0;
  bit  snk_burst     = 1'b0;

  dir_row_t dir_tab [20] = '{
    '{1'b0, 8'd0, 8'h00, 8'h41, 1'b1, 13},
    '{1'b0, 8'd0, 8'h00, 8'h00, 1'b0, 6},
    '{1'b0, 8'd0, 8'h00, 8'hFF, 1'b0, 0},
    '{1'b0, 8'd0, 8'h00, CH_D,  1'b0, 1},
    '{1'b0, 8'd0, 8'h00, CH_L,  1'b0, 1},
    '{1'b0, 8'd0, 8'h00, CH_E,  1'b0, 4},
    '{1'b0, 8'd0, 8'h00, CH_D,  1'b1, 9},
    // 'd' whose "le" would run past the end
    '{1'b0, 8'd0, 8'h00, CH_D,  1'b0, 6},
    '{1'b0, 8'd0, 8'h00, CH_L,  1'b1, 8},
    '{1'b0, 8'd0, 8'h00, CH_D,  1'b0, 6},
    '{1'b0, 8'd0, 8'h00, CH_L,  1'b0, 0},
    '{1'b0, 8'd0, 8'h00, CH_E,  1'b1, 12},
    // insertion before the first character, with stuffing on top
    '{1'b1, 8'd1, 8'hFF, CH_D,  1'b0, 6},
    '{1'b0, 8'd0, 8'h00, CH_L,  1'b0, 0},
    '{1'b0, 8'd0, 8'h00, CH_E,  1'b1, 19},
    // single character string, the longest run of results
    '{1'b0, 8'd0, 8'h00, CH_D,  1'b1, 20},
    '{1'b1, 8'd3, 8'h00, 8'h61, 1'b0, 6},
    '{1'b0, 8'd0, 8'h00, 8'h62, 1'b0, 0},
    '{1'b0, 8'd0, 8'h00, 8'h63, 1'b0, 1},
    '{1'b0, 8'd0, 8'h00, 8'h71, 1'b1, 16}
  };

  function automatic void push_beat(input logic [7:0] b, input logic fe);
    frame_beat_t nb;
    nb.out_byte  = b;
    nb.run_last  = 1'b0;
    nb.frame_end = fe;
    beat_q.push_back(nb);
  endfunction

  function automatic void push_dle();
    push_beat(CH_D, 1'b0);
    push_beat(CH_L, 1'b0);
    push_beat(CH_E, 1'b0);
  endfunction

  // one data character, nk = how many lookahead characters are known
  function automatic void emit_char(input logic [7:0] c, input int nk,
                                    input logic [7:0] k1, input logic [7:0] k2);
    if (ins_pos != 8'd0 && char_pos == ins_pos - 8'd1) begin
      push_dle();
      push_beat(ins_chr, 1'b0);
      push_dle();
    end
    if (c == CH_D && nk >= 2 && k1 == CH_L && k2 == CH_E)
      push_dle();
    push_beat(c, 1'b0);
    if (char_pos < 8'(MAX_LEN_DEF))
      char_pos = char_pos + 8'd1;
  endfunction

  // expected bytes for one accepted character, returns how many
  function automatic int frame_char(input logic [7:0] ch, input logic lst);
    logic [7:0] win [3];
    int         cnt;
    int         start;
    int         nk;
    start = beat_q.size();
    if (!frame_open) begin
      push_dle();
      push_beat(CH_S, 1'b0);
      push_beat(CH_T, 1'b0);
      push_beat(CH_X, 1'b0);
      frame_open = 1'b1;
      look_cnt   = 2'd0;
      char_pos   = 8'd0;
    end
    cnt = (look_cnt > 2'd2) ? 2 : int'(look_cnt);
    win[0] = look_q[0];
    win[1] = look_q[1];
    win[2] = 8'd0;
    win[cnt] = ch;
    cnt++;
    if (!lst) begin
      if (cnt == 3) begin
        emit_char(win[0], 2, win[1], win[2]);
        look_q[0] = win[1];
        look_q[1] = win[2];
        look_cnt  = 2'd2;
      end else begin
        look_q[0] = win[0];
        look_q[1] = (cnt >= 2) ? win[1] : 8'd0;
        look_cnt  = 2'(cnt);
      end
    end else begin
      for (int i = 0; i < cnt; i++) begin
        nk = cnt - 1 - i;
        emit_char(win[i], nk, (nk >= 1) ? win[i + 1] : 8'd0,
                  (nk >= 2) ? win[(i + 2) % 3] : 8'd0);
      end
      push_dle();
      push_beat(CH_E, 1'b0);
      push_beat(CH_T, 1'b0);
      push_beat(CH_X, 1'b1);
      look_q[0]  = 8'd0;
      look_q[1]  = 8'd0;
      look_cnt   = 2'd0;
      char_pos   = 8'd0;
      frame_open = 1'b0;
    end
    if (beat_q.size() > start)
      beat_q[beat_q.size() - 1].run_last = 1'b1;
    return beat_q.size() - start;
  endfunction

  // write a register, then read it back
  task automatic reg_access(input logic idx, input logic [7:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_INSERT_POSITION)
      ins_pos = val;
    else
      ins_chr = val;
    regs_written++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (rd[7:0] !== val) begin
      $error("prdata at %0h: expected %02h, got %02h", {idx, 2'b00}, val, rd[7:0]);
      fail_cnt++;
    end
  endtask

  // drain every pending byte, then let the pipeline settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (beat_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic send_char(input logic [7:0] ch, input logic lst, input int exp_n);
    int gap;
    int n;
    if ($urandom_range(0, 19) == 0)
      src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= ch;
    in_ch.last_char <= lst;
    do @(posedge clk); while (!in_ch.ready);
    n = frame_char(ch, lst);
    chars_sent++;
    if (lst)
      frames_sent++;
    if (exp_n >= 0 && n != exp_n) begin
      $error("result count for %02h: table %0d, predicted %0d", ch, exp_n, n);
      fail_cnt++;
    end
  endtask

  // stuffy strings lean on 'd', 'l' and 'e' so that stuffing shows up often
  task automatic send_string(input int len, input bit stuffy);
    logic [7:0] ch;
    int         sel;
    for (int i = 0; i < len; i++) begin
      sel = stuffy ? $urandom_range(0, 5) : 5;
      case (sel)
        0: begin
          ch = CH_D;
        end
        1: begin
          ch = CH_L;
        end
        2: begin
          ch = CH_E;
        end
        default: begin
          ch = 8'($urandom_range(0, 255));
        end
      endcase
      send_char(ch, i == len - 1, -1);
    end
  endtask

  // receiver with random stalls
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0)
        snk_burst = !snk_burst;
      stall = snk_burst ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (beat_q.size() == 0) begin
        $error("output beat with nothing expected: out_byte %02h", out_ch.out_byte);
        fail_cnt++;
      end else begin
        exp_beat = beat_q.pop_front();
        bytes_checked++;
        if (out_ch.out_byte !== exp_beat.out_byte) begin
          $error("out_byte: expected %02h, got %02h", exp_beat.out_byte, out_ch.out_byte);
          fail_cnt++;
        end
        if (out_ch.run_last !== exp_beat.run_last) begin
          $error("run_last: expected %0b, got %0b", exp_beat.run_last, out_ch.run_last);
          fail_cnt++;
        end
        if (out_ch.frame_end !== exp_beat.frame_end) begin
          $error("frame_end: expected %0b, got %0b", exp_beat.frame_end, out_ch.frame_end);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0] pos_set [5];
    logic [7:0] chr_set [5];
    int         n;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= 3'd0;
    pwdata          <= 32'd0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'd0;
    in_ch.last_char <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].cfg) begin
        wait_idle();
        reg_access(REG_INSERT_POSITION, dir_tab[r].pos);
        reg_access(REG_INSERT_CHAR, dir_tab[r].chr);
      end
      send_char(dir_tab[r].ch, dir_tab[r].lst, dir_tab[r].exp_n);
    end

    pos_set = '{8'd255, 8'd0, 8'($urandom_range(1, 6)), 8'd2, 8'($urandom_range(1, 10))};
    chr_set = '{8'hFF, 8'h00, 8'($urandom_range(0, 255)), CH_D, 8'($urandom_range(0, 255))};
    foreach (pos_set[p]) begin
      wait_idle();
      reg_access(REG_INSERT_POSITION, pos_set[p]);
      reg_access(REG_INSERT_CHAR, chr_set[p]);
      n = chars_sent;
      while (chars_sent - n < 15)
        send_string(($urandom_range(0, 7) == 0) ? $urandom_range(9, 14)
                                                 : $urandom_range(1, 6),
                    $urandom_range(0, 4) != 0);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d characters in %0d frames, %0d output bytes checked",
             chars_sent, frames_sent, bytes_checked);
    $display("%0d register writes, insertion positions 0 to 255, strings up to 14 long",
             regs_written);
    if (fail_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> dle_character_stuffing_framer.f
+incdir+sv
sv/dlecs_pkg.sv
sv/dlecs_if.sv
sv/dlecs_front.sv
sv/dlecs_fifo.sv
sv/dlecs_back.sv
sv/dle_character_stuffing_framer.sv
tb/testbench.sv
